// File: rtl/pst_pkg.sv
package pst_pkg;

    localparam int unsigned RING_FRAMES = 16384;
    localparam int unsigned FILL_SAT_W  = 17;

    localparam int unsigned SEQ_W    = 32;
    localparam int unsigned GAP_W    = 31;
    localparam int unsigned FRAMES_W = 13;
    localparam int unsigned LEVEL_W  = 15;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned DRIFT_CNT_W = 3;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 15;

    localparam logic [SEQ_W-1:0]       HALF_SPACE     = 32'h8000_0000;
    localparam logic [DRIFT_CNT_W-1:0] DRIFT_PERIOD   = 3'd5;
    localparam logic [1:0]             DRIFT_HEADROOM = 2'd3;

    localparam logic [FRAMES_W-1:0] PERIOD_RESET = 13'd128;
    localparam logic [LEVEL_W-1:0]  JITTER_RESET = 15'd256;
    localparam logic [FRAMES_W-1:0] CAP_RESET    = 13'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_FRAMES = 2'd0,
        CFG_JITTER_TARGET = 2'd1,
        CFG_FILL_CAP      = 2'd2,
        CFG_DRIFT_ENABLE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        VERDICT_ACCEPTED = 3'd0,
        VERDICT_DUPLICATE = 3'd1,
        VERDICT_REORDERED = 3'd2,
        VERDICT_LOST_SLOT = 3'd3,
        VERDICT_UNPACK_EMPTY = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        DRIFT_NONE   = 2'd0,
        DRIFT_DROP   = 2'd1,
        DRIFT_REPEAT = 2'd2
    } t_drift;

    typedef struct packed {
        logic [FRAMES_W-1:0] period_frames;
        logic [LEVEL_W-1:0]  jitter_target;
        logic [FRAMES_W-1:0] fill_cap;
        logic                drift_enable;
    } t_cfg;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq_number;
        logic [COUNT_W-1:0]  sample_count;
        logic                payload_present;
        logic [FRAMES_W-1:0] unpacked_frames;
        logic [LEVEL_W-1:0]  fill_level;
    } t_item;

    typedef struct packed {
        logic [SEQ_W-1:0]       last_seq;
        logic                   last_valid;
        logic [DRIFT_CNT_W-1:0] drift_count;
    } t_track;

    typedef struct packed {
        t_verdict            verdict;
        logic                restart;
        logic [GAP_W-1:0]    gap_packets;
        logic [FRAMES_W-1:0] conceal_frames;
        logic [FRAMES_W-1:0] write_frames;
        t_drift              drift_action;
    } t_result;

endpackage

// File: rtl/pst_classify.sv
module pst_classify #(
    parameter int unsigned RING_FRAMES = pst_pkg::RING_FRAMES
) (
    input  pst_pkg::t_cfg    i_cfg,
    input  pst_pkg::t_item   i_item,
    input  pst_pkg::t_track  i_track,
    output pst_pkg::t_result o_result,
    output pst_pkg::t_track  o_track
);
    import pst_pkg::*;

    logic [SEQ_W-1:0]       delta;
    logic                   restart;
    logic                   eff_valid;
    logic                   is_dup;
    logic                   is_reord;
    logic [GAP_W-1:0]       gap;
    logic [COUNT_W-1:0]     len_raw;
    logic [FRAMES_W-1:0]    slot_len;
    logic [FRAMES_W-1:0]    wr_len;
    logic [FILL_SAT_W-1:0]  fill_sat;
    logic [FILL_SAT_W-1:0]  drop_thr;
    logic [DRIFT_CNT_W-1:0] cnt_inc;
    t_drift                 drift_pick;

    assign delta     = i_item.seq_number - i_track.last_seq;
    assign restart   = i_track.last_valid && (delta > HALF_SPACE);
    assign eff_valid = i_track.last_valid && !restart;
    assign is_dup    = eff_valid && (delta == '0);
    assign is_reord  = eff_valid && delta[SEQ_W-1];

    assign gap = (eff_valid && (delta >= SEQ_W'(2))) ? GAP_W'(delta - SEQ_W'(1)) : '0;

    assign len_raw  = (i_item.sample_count != '0) ? i_item.sample_count
                                                  : COUNT_W'(i_cfg.period_frames);
    assign slot_len = (len_raw > COUNT_W'(i_cfg.fill_cap)) ? i_cfg.fill_cap
                                                          : len_raw[FRAMES_W-1:0];
    assign wr_len   = (i_item.unpacked_frames > i_cfg.fill_cap) ? i_cfg.fill_cap
                                                                : i_item.unpacked_frames;

    assign fill_sat = (FILL_SAT_W'(i_item.fill_level) > FILL_SAT_W'(RING_FRAMES))
                      ? FILL_SAT_W'(RING_FRAMES) : FILL_SAT_W'(i_item.fill_level);
    assign drop_thr = FILL_SAT_W'(i_cfg.jitter_target)
                      + FILL_SAT_W'(i_cfg.period_frames) * FILL_SAT_W'(DRIFT_HEADROOM);
    assign cnt_inc  = i_track.drift_count + DRIFT_CNT_W'(1);

    always_comb begin
        if (fill_sat > drop_thr) begin
            drift_pick = DRIFT_DROP;
        end else if ((fill_sat != '0) && (fill_sat < FILL_SAT_W'(i_cfg.period_frames))
                     && (i_cfg.fill_cap != '0)) begin
            drift_pick = DRIFT_REPEAT;
        end else begin
            drift_pick = DRIFT_NONE;
        end
    end

    always_comb begin
        o_result.verdict        = VERDICT_ACCEPTED;
        o_result.restart        = restart;
        o_result.gap_packets    = '0;
        o_result.conceal_frames = '0;
        o_result.write_frames   = '0;
        o_result.drift_action   = DRIFT_NONE;
        o_track.last_seq        = restart ? '0 : i_track.last_seq;
        o_track.last_valid      = eff_valid;
        o_track.drift_count     = i_track.drift_count;
        if (is_dup) begin
            o_result.verdict = VERDICT_DUPLICATE;
        end else if (is_reord) begin
            o_result.verdict = VERDICT_REORDERED;
        end else begin
            o_result.gap_packets = gap;
            if (gap != '0) begin
                o_result.conceal_frames = slot_len;
            end
            o_track.last_seq   = i_item.seq_number;
            o_track.last_valid = 1'b1;
            if (!i_item.payload_present) begin
                o_result.verdict        = VERDICT_LOST_SLOT;
                o_result.conceal_frames = slot_len;
            end else if (wr_len == '0) begin
                o_result.verdict = VERDICT_UNPACK_EMPTY;
            end else begin
                o_result.write_frames = wr_len;
                if (i_cfg.drift_enable) begin
                    if (cnt_inc >= DRIFT_PERIOD) begin
                        o_track.drift_count   = '0;
                        o_result.drift_action = drift_pick;
                    end else begin
                        o_track.drift_count = cnt_inc;
                    end
                end
            end
        end
    end

endmodule

// File: rtl/packet_sequence_tracker.sv
// Sequence tracker for received audio packets. Each transfer on the input
// channel carries one packet header and yields exactly one result transfer:
// verdict, restart flag, gap to conceal, concealed slot length, write length
// and drift action. A packet is accepted every cycle while o_stall is low;
// its result is registered in the output register or, while that is held, in
// the skid register. This two-entry output stage (output register plus skid
// register) lets the input keep moving while a result waits, so o_stall rises
// only when both entries are full. Classification and tracking-state update
// for one header is a single combinational compare-and-update. Configuration
// writes are always ready and must be made while no result is outstanding.
module packet_sequence_tracker #(
    parameter int unsigned RING_FRAMES = pst_pkg::RING_FRAMES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pst_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pst_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [pst_pkg::SEQ_W-1:0]       i_seq_number,
    input  logic [pst_pkg::COUNT_W-1:0]     i_sample_count,
    input  logic                            i_payload_present,
    input  logic [pst_pkg::FRAMES_W-1:0]    i_unpacked_frames,
    input  logic [pst_pkg::LEVEL_W-1:0]     i_fill_level,

    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [2:0]                      o_verdict,
    output logic                            o_restart,
    output logic [pst_pkg::GAP_W-1:0]       o_gap_packets,
    output logic [pst_pkg::FRAMES_W-1:0]    o_conceal_frames,
    output logic [pst_pkg::FRAMES_W-1:0]    o_write_frames,
    output logic [1:0]                      o_drift_action
);
    import pst_pkg::*;

    t_cfg    r_cfg;
    t_track  r_track;
    t_track  n_track;
    t_item   item;
    t_result result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_fire;
    logic    out_free;
    logic    cfg_fire;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_frames <= PERIOD_RESET;
            r_cfg.jitter_target <= JITTER_RESET;
            r_cfg.fill_cap      <= CAP_RESET;
            r_cfg.drift_enable  <= 1'b0;
        end else if (cfg_fire) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD_FRAMES: r_cfg.period_frames <= i_cfg_data[FRAMES_W-1:0];
                CFG_JITTER_TARGET: r_cfg.jitter_target <= i_cfg_data[LEVEL_W-1:0];
                CFG_FILL_CAP:      r_cfg.fill_cap      <= i_cfg_data[FRAMES_W-1:0];
                CFG_DRIFT_ENABLE:  r_cfg.drift_enable  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign item.seq_number      = i_seq_number;
    assign item.sample_count    = i_sample_count;
    assign item.payload_present = i_payload_present;
    assign item.unpacked_frames = i_unpacked_frames;
    assign item.fill_level      = i_fill_level;

    pst_classify #(
        .RING_FRAMES (RING_FRAMES)
    ) u_classify (
        .i_cfg    (r_cfg),
        .i_item   (item),
        .i_track  (r_track),
        .o_result (result),
        .o_track  (n_track)
    );

    assign o_stall  = r_skid_valid;
    assign in_fire  = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= '0;
        end else if (in_fire) begin
            r_track <= n_track;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= result;
            end
        end else if (in_fire) begin
            r_skid <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_verdict        = r_out.verdict;
    assign o_restart        = r_out.restart;
    assign o_gap_packets    = r_out.gap_packets;
    assign o_conceal_frames = r_out.conceal_frames;
    assign o_write_frames   = r_out.write_frames;
    assign o_drift_action   = r_out.drift_action;

endmodule

// File: dv/tracker_checker.sv
module tracker_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [pst_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pst_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic                           i_pkt_valid,
    input  logic                           i_pkt_stall,
    input  pst_pkg::t_item                 i_pkt,

    input  logic                           i_res_valid,
    input  logic                           i_res_stall,
    input  pst_pkg::t_result               i_res,

    output int                             o_errors,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pst_pkg::*;

    int unsigned cfg_period;
    int unsigned cfg_jitter;
    int unsigned cfg_cap;
    logic        cfg_drift_en;

    logic [SEQ_W-1:0]       trk_last;
    logic                   trk_valid;
    logic [DRIFT_CNT_W-1:0] trk_drift;

    t_result expected_results[$];
    int      n_errors = 0;

    function automatic logic [FRAMES_W-1:0] slot_frames(logic [COUNT_W-1:0] announced);
        int unsigned len;
        len = (announced != 0) ? int'(announced) : cfg_period;
        if (len > cfg_cap)
            len = cfg_cap;
        return len[FRAMES_W-1:0];
    endfunction

    function automatic t_result classify_packet(t_item pkt);
        t_result          res;
        logic [SEQ_W-1:0] delta;
        int unsigned      fill;
        int unsigned      wr;
        res = '0;
        fill = pkt.fill_level;
        if (fill > RING_FRAMES)
            fill = RING_FRAMES;

        delta = pkt.seq_number - trk_last;
        if (trk_valid && delta > HALF_SPACE) begin
            res.restart = 1'b1;
            trk_valid = 1'b0;
            trk_last = '0;
        end

        delta = pkt.seq_number - trk_last;
        if (trk_valid && delta == 0) begin
            res.verdict = VERDICT_DUPLICATE;
        end else if (trk_valid && delta[SEQ_W-1]) begin
            res.verdict = VERDICT_REORDERED;
        end else begin
            if (trk_valid && delta >= 2)
                res.gap_packets = GAP_W'(delta - 1);
            if (res.gap_packets != 0)
                res.conceal_frames = slot_frames(pkt.sample_count);
            trk_last = pkt.seq_number;
            trk_valid = 1'b1;
            if (!pkt.payload_present) begin
                res.verdict = VERDICT_LOST_SLOT;
                res.conceal_frames = slot_frames(pkt.sample_count);
            end else begin
                wr = (pkt.unpacked_frames > cfg_cap) ? cfg_cap : int'(pkt.unpacked_frames);
                res.write_frames = wr[FRAMES_W-1:0];
                if (wr == 0) begin
                    res.verdict = VERDICT_UNPACK_EMPTY;
                end else if (cfg_drift_en) begin
                    trk_drift = trk_drift + 1'b1;
                    if (trk_drift >= DRIFT_PERIOD) begin
                        trk_drift = '0;
                        if (fill > cfg_jitter + cfg_period * int'(DRIFT_HEADROOM))
                            res.drift_action = DRIFT_DROP;
                        else if (fill > 0 && fill < cfg_period && cfg_cap > 0)
                            res.drift_action = DRIFT_REPEAT;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg_period = PERIOD_RESET;
            cfg_jitter = JITTER_RESET;
            cfg_cap = CAP_RESET;
            cfg_drift_en = 1'b0;
            trk_last = '0;
            trk_valid = 1'b0;
            trk_drift = '0;
            expected_results.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no packet outstanding");
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("verdict", want.verdict, i_res.verdict);
                    check_field("restart", want.restart, i_res.restart);
                    check_field("gap_packets", want.gap_packets, i_res.gap_packets);
                    check_field("conceal_frames", want.conceal_frames, i_res.conceal_frames);
                    check_field("write_frames", want.write_frames, i_res.write_frames);
                    check_field("drift_action", want.drift_action, i_res.drift_action);
                end
            end
            if (i_pkt_valid && !i_pkt_stall)
                expected_results.push_back(classify_packet(i_pkt));
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PERIOD_FRAMES: cfg_period = i_cfg_data[FRAMES_W-1:0];
                    CFG_JITTER_TARGET: cfg_jitter = i_cfg_data[LEVEL_W-1:0];
                    CFG_FILL_CAP:      cfg_cap = i_cfg_data[FRAMES_W-1:0];
                    CFG_DRIFT_ENABLE:  cfg_drift_en = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending <= expected_results.size();
        o_errors <= n_errors;
    end

endmodule

// File: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pst_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;

    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [SEQ_W-1:0]      i_seq_number = '0;
    logic [COUNT_W-1:0]    i_sample_count = '0;
    logic                  i_payload_present = 1'b0;
    logic [FRAMES_W-1:0]   i_unpacked_frames = '0;
    logic [LEVEL_W-1:0]    i_fill_level = '0;

    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [2:0]            o_verdict;
    logic                  o_restart;
    logic [GAP_W-1:0]      o_gap_packets;
    logic [FRAMES_W-1:0]   o_conceal_frames;
    logic [FRAMES_W-1:0]   o_write_frames;
    logic [1:0]            o_drift_action;

    int               errors;
    int               pending;
    logic [SEQ_W-1:0] last_sent = '0;
    int               burst_left = 0;
    int               stall_run = 0;
    bit               draining = 1'b0;

    packet_sequence_tracker dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_seq_number      (i_seq_number),
        .i_sample_count    (i_sample_count),
        .i_payload_present (i_payload_present),
        .i_unpacked_frames (i_unpacked_frames),
        .i_fill_level      (i_fill_level),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_verdict         (o_verdict),
        .o_restart         (o_restart),
        .o_gap_packets     (o_gap_packets),
        .o_conceal_frames  (o_conceal_frames),
        .o_write_frames    (o_write_frames),
        .o_drift_action    (o_drift_action)
    );

    tracker_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pkt_valid (i_valid),
        .i_pkt_stall (o_stall),
        .i_pkt       ({i_seq_number, i_sample_count, i_payload_present,
                       i_unpacked_frames, i_fill_level}),
        .i_res_valid (o_valid),
        .i_res_stall (i_stall),
        .i_res       ({o_verdict, o_restart, o_gap_packets, o_conceal_frames,
                       o_write_frames, o_drift_action}),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        int r;
        if (draining) begin
            i_stall <= 1'b0;
        end else if (stall_run > 0) begin
            stall_run--;
        end else begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
                i_stall <= 1'b0;
                stall_run = $urandom_range(5, 60);
            end else if (r < 8) begin
                i_stall <= 1'b1;
                stall_run = $urandom_range(0, 2);
            end else if (r < 9) begin
                i_stall <= 1'b0;
                stall_run = $urandom_range(0, 2);
            end else begin
                i_stall <= 1'b1;
                stall_run = $urandom_range(10, 50);
            end
        end
    end

    function automatic int pick_idle();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_item random_packet(logic [SEQ_W-1:0] prev);
        t_item       pkt;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            pkt.seq_number = prev + 1;
        else if (r < 67)
            pkt.seq_number = prev + $urandom_range(2, 6);
        else if (r < 72)
            pkt.seq_number = prev;
        else if (r < 75)
            pkt.seq_number = prev + HALF_SPACE;
        else if (r < 81)
            pkt.seq_number = prev - $urandom_range(1, 20);
        else if (r < 85)
            pkt.seq_number = prev + $urandom;
        else if (r < 90)
            pkt.seq_number = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        else if (r < 95)
            pkt.seq_number = prev + 32'h7FFF_FFFF - $urandom_range(0, 3);
        else
            pkt.seq_number = $urandom;

        r = $urandom_range(0, 9);
        if (r < 2)
            pkt.sample_count = '0;
        else if (r < 3)
            pkt.sample_count = '1;
        else if (r < 7)
            pkt.sample_count = COUNT_W'($urandom_range(1, 5000));
        else
            pkt.sample_count = COUNT_W'($urandom);

        pkt.payload_present = ($urandom_range(0, 9) != 0);

        r = $urandom_range(0, 19);
        if (r < 2)
            pkt.unpacked_frames = '0;
        else if (r < 3)
            pkt.unpacked_frames = FRAMES_W'(4096);
        else if (r < 6)
            pkt.unpacked_frames = FRAMES_W'($urandom_range(1, 16));
        else
            pkt.unpacked_frames = FRAMES_W'($urandom_range(0, 4096));

        r = $urandom_range(0, 19);
        if (r < 2)
            pkt.fill_level = '0;
        else if (r < 6)
            pkt.fill_level = LEVEL_W'($urandom_range(1, 200));
        else if (r < 8)
            pkt.fill_level = LEVEL_W'(RING_FRAMES);
        else if (r < 10)
            pkt.fill_level = LEVEL_W'($urandom_range(RING_FRAMES + 1, 32767));
        else
            pkt.fill_level = LEVEL_W'($urandom_range(0, RING_FRAMES));
        return pkt;
    endfunction

    task automatic send_packet(t_item pkt);
        int idle;
        i_valid <= 1'b1;
        i_seq_number <= pkt.seq_number;
        i_sample_count <= pkt.sample_count;
        i_payload_present <= pkt.payload_present;
        i_unpacked_frames <= pkt.unpacked_frames;
        i_fill_level <= pkt.fill_level;
        do @(posedge i_clk); while (o_stall);
        last_sent = pkt.seq_number;
        idle = pick_idle();
        if (idle > 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_config(logic [CFG_DATA_W-1:0] period, logic [CFG_DATA_W-1:0] jitter,
                               logic [CFG_DATA_W-1:0] cap, logic [CFG_DATA_W-1:0] enable);
        settle();
        write_register(CFG_PERIOD_FRAMES, period);
        write_register(CFG_JITTER_TARGET, jitter);
        write_register(CFG_FILL_CAP, cap);
        write_register(CFG_DRIFT_ENABLE, enable);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_packet(t_item'{32'd0, 16'd0, 1'b1, 13'd100, 15'd0});
        send_packet(t_item'{32'd0, 16'd10, 1'b1, 13'd100, 15'd0});
        send_packet(t_item'{32'd1, 16'd10, 1'b1, 13'd4096, 15'd32767});
        send_packet(t_item'{32'd5, 16'd0, 1'b1, 13'd50, 15'd100});
        send_packet(t_item'{32'h8000_0005, 16'd10, 1'b1, 13'd50, 15'd100});
        send_packet(t_item'{32'd4, 16'd10, 1'b1, 13'd50, 15'd100});
        send_packet(t_item'{32'hFFFF_FFFE, 16'hFFFF, 1'b1, 13'd50, 15'd100});
        send_packet(t_item'{32'hFFFF_FFFF, 16'hFFFF, 1'b0, 13'd50, 15'd100});
        send_packet(t_item'{32'd1, 16'd300, 1'b1, 13'd0, 15'd100});
        send_packet(t_item'{32'h8000_0000, 16'd20, 1'b1, 13'd20, 15'd100});
        send_packet(t_item'{32'd1, 16'd20, 1'b1, 13'd20, 15'd100});
        send_packet(t_item'{32'd2, 16'd0, 1'b0, 13'd20, 15'd100});
        send_packet(t_item'{32'h8000_0002, 16'd20, 1'b1, 13'd20, 15'd100});
        send_packet(t_item'{32'd3, 16'd20, 1'b1, 13'd1, 15'd16385});

        load_config(15'd100, 15'd200, 15'd4096, 15'd1);
        for (int n = 0; n < 5; n++)
            send_packet(t_item'{32'(10 + n), 16'd0, 1'b1, 13'd64, 15'd32767});
        for (int n = 0; n < 5; n++)
            send_packet(t_item'{32'(15 + n), 16'd0, 1'b1, 13'd64, 15'd50});

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: load_config(15'd1, 15'd0, 15'd1, 15'd1);
                1: load_config(15'd4096, 15'd16384, 15'd4096, 15'd1);
                2: load_config(15'd0, 15'h7FFF, 15'd0, 15'd1);
                3: load_config(15'h7FFF, 15'd0, 15'd8191, 15'd0);
                4: load_config(15'd128, 15'd256, 15'd256, 15'd1);
                default: load_config(CFG_DATA_W'($urandom_range(1, 4096)),
                                     CFG_DATA_W'($urandom_range(0, 16384)),
                                     CFG_DATA_W'($urandom_range(1, 4096)),
                                     CFG_DATA_W'($urandom_range(0, 1)));
            endcase
            for (int n = 0; n < 200; n++)
                send_packet(random_packet(last_sent));
        end

        settle();
        draining = 1'b1;
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #10ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
